// ===== hdl/pps_pkg.sv =====
package pps_pkg;

    localparam int unsigned PlanDepthDefault = 1024;
    localparam logic [23:0] LookaheadReset = 24'd32768;
    localparam logic [19:0] MaxLinReset    = 20'd19661;
    localparam logic [19:0] MaxAngReset    = 20'd65536;
    localparam logic [65:0] CurvMinRaw     = 66'd4294967;

    localparam logic [1:0] RegLookahead = 2'd0;
    localparam logic [1:0] RegMaxLin    = 2'd1;
    localparam logic [1:0] RegMaxAng    = 2'd2;

    localparam logic CmdLoad    = 1'b0;
    localparam logic CmdCompute = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic               first_point;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in;

    typedef struct packed {
        logic [19:0]        linear_speed;
        logic signed [31:0] angular_speed;
        logic               plan_empty;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_DIST,
        ST_SQ,
        ST_CMP,
        ST_ROT,
        ST_NUM,
        ST_MLD,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_pose;   // capture pose, start walk at last point
        logic rd_req;      // issue store read at walk index
        logic calc_dist;   // offset of the point just read
        logic calc_sq;     // square the offset
        logic step;        // compare, move carrot
        logic calc_rot;    // rotation products
        logic calc_num;    // numerator products
        logic mul_start;   // load shift-add multipliers
        logic mul_step;
        logic div_start;
        logic div_step;
        logic emit;
        logic emit_empty;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic walk_end;    // point in range or index exhausted
        logic mul_done;
        logic div_done;
    } t_status;

endpackage

// ===== hdl/pps_ram.sv =====
module pps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/pps_ctrl.sv =====
module pps_ctrl import pps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_go,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_go) begin
                    o_cmd.load_pose = 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (i_status.empty) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.rd_req = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: n_state = ST_DIST;
            ST_DIST: begin
                o_cmd.calc_dist = 1'b1;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.calc_sq = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
                n_state = i_status.walk_end ? ST_ROT : ST_RD;
            end
            ST_ROT: begin
                o_cmd.calc_rot = 1'b1;
                n_state = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.calc_num = 1'b1;
                n_state = ST_MLD;
            end
            ST_MLD: begin
                o_cmd.mul_start = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (i_status.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== hdl/pps_dp.sv =====
module pps_dp import pps_pkg::*; #(
    parameter int unsigned PLAN_DEPTH = PlanDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in         i_in,
    input  t_cmd        i_cmd,
    input  logic [23:0] i_look,
    input  logic [19:0] i_max_lin,
    input  logic [19:0] i_max_ang,
    output t_status     o_status,
    output logic        o_valid,
    output t_out        o_out
);
    localparam int unsigned AW = $clog2(PLAN_DEPTH);
    localparam int unsigned LW = $clog2(PLAN_DEPTH + 1);
    localparam logic [LW-1:0] DepthL = LW'(PLAN_DEPTH);

    logic [LW-1:0] r_len;
    logic          r_valid;
    t_out          r_out;

    // plan load: restart on first point, drop when full
    logic          load_go;
    logic [LW-1:0] wr_pos;
    logic          wr_en;
    assign load_go = i_start && !i_busy && (i_in.cmd == CmdLoad);
    assign wr_pos  = i_in.first_point ? '0 : r_len;
    assign wr_en   = load_go && (wr_pos < DepthL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (wr_en) begin
            r_len <= wr_pos + LW'(1);
        end else if (load_go) begin
            r_len <= wr_pos;
        end
    end

    // walk registers
    logic signed [31:0] r_rx, r_ry;
    logic signed [15:0] r_qz, r_qw;
    logic [LW-1:0]      r_idx;     // next point to read plus one
    logic [AW-1:0]      r_rd_addr;
    logic               r_first;   // next compare is for the last point
    logic signed [32:0] r_dx, r_dy, r_cdx, r_cdy;
    logic [65:0]        r_d, r_cd;
    logic [47:0]        r_look2;
    logic [31:0]        px, py;

    pps_ram #(.WIDTH(32), .DEPTH(PLAN_DEPTH)) u_ram_x (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_pos[AW-1:0]),
        .i_wdata(i_in.pos_x), .i_raddr(r_rd_addr), .o_rdata(px));
    pps_ram #(.WIDTH(32), .DEPTH(PLAN_DEPTH)) u_ram_y (
        .i_clk(i_clk), .i_we(wr_en), .i_waddr(wr_pos[AW-1:0]),
        .i_wdata(i_in.pos_y), .i_raddr(r_rd_addr), .o_rdata(py));

    logic [32:0] mdx, mdy;
    assign mdx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign mdy = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);

    logic far;
    assign far = r_d > 66'(r_look2);
    assign o_status.empty    = (r_len == '0);
    assign o_status.walk_end = !far || (r_idx == '0);

    // rotation terms
    logic signed [32:0] r_c, r_s;
    logic [32:0]        r_n;
    logic signed [66:0] r_p1, r_p2;
    logic               r_small;
    logic signed [67:0] ysum;
    logic [66:0]        ymag;
    assign ysum = 68'(r_p1) - 68'(r_p2);
    assign ymag = ysum[67] ? 67'(-ysum) : ysum[66:0];

    // shift-add multipliers, then divider
    localparam int unsigned NW = 104;
    localparam int unsigned DW = 99;
    localparam int unsigned MulSteps = 33;
    logic [NW-1:0] r_num, r_ma;
    logic [19:0]   r_mb;
    logic [DW-1:0] r_den, r_da;
    logic [32:0]   r_db;
    logic [5:0]    r_mcnt;
    logic [DW:0]   r_rem;
    logic [6:0]    r_cnt;
    logic          r_neg;
    logic [DW:0]   rem_sh;
    assign rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign o_status.mul_done = (r_mcnt == 6'd0);
    assign o_status.div_done = (r_cnt == 7'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pose) begin
            r_rx    <= i_in.pos_x;
            r_ry    <= i_in.pos_y;
            r_qz    <= i_in.quat_z;
            r_qw    <= i_in.quat_w;
            r_idx   <= r_len;
            r_first <= 1'b1;
            r_look2 <= 48'(i_look) * 48'(i_look);
        end
        if (i_cmd.rd_req) begin
            r_rd_addr <= AW'(r_idx - LW'(1));
            r_idx     <= r_idx - LW'(1);
        end
        if (i_cmd.calc_dist) begin
            r_dx <= 33'(signed'(px)) - 33'(r_rx);
            r_dy <= 33'(signed'(py)) - 33'(r_ry);
        end
        if (i_cmd.calc_sq) begin
            r_d <= 66'(mdx) * 66'(mdx) + 66'(mdy) * 66'(mdy);
        end
        // keep the point as carrot while out of range; the last point always starts it
        if (i_cmd.step) begin
            r_first <= 1'b0;
            if (far || r_first) begin
                r_cd  <= r_d;
                r_cdx <= r_dx;
                r_cdy <= r_dy;
            end
        end
        if (i_cmd.calc_rot) begin
            r_small <= (r_cd <= CurvMinRaw);
            if (r_qz == 16'sd0 && r_qw == 16'sd0) begin
                r_c <= 33'sd1;
                r_s <= 33'sd0;
                r_n <= 33'd1;
            end else begin
                r_c <= 33'(r_qw * r_qw) - 33'(r_qz * r_qz);
                r_s <= 33'(r_qw * r_qz) <<< 1;
                r_n <= 33'(32'(r_qw * r_qw)) + 33'(32'(r_qz * r_qz));
            end
        end
        if (i_cmd.calc_num) begin
            r_p1 <= 67'(r_c) * 67'(r_cdy);
            r_p2 <= 67'(r_s) * 67'(r_cdx);
        end
        // numerator |Y| * 2^17 * max_ang and denominator D * n, one bit a cycle
        if (i_cmd.mul_start) begin
            r_ma   <= NW'({ymag, 17'd0});
            r_mb   <= i_max_ang;
            r_da   <= DW'(r_cd);
            r_db   <= r_n;
            r_num  <= '0;
            r_den  <= '0;
            r_neg  <= ysum[67];
            r_mcnt <= 6'(MulSteps);
        end else if (i_cmd.mul_step) begin
            r_mcnt <= r_mcnt - 6'd1;
            if (r_mb[0]) begin
                r_num <= r_num + r_ma;
            end
            if (r_db[0]) begin
                r_den <= r_den + r_da;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
            r_da <= r_da << 1;
            r_db <= r_db >> 1;
        end
        if (i_cmd.div_start) begin
            r_cnt <= 7'(NW);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 7'd1;
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sh - {1'b0, r_den};
                r_num <= {r_num[NW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_num <= {r_num[NW-2:0], 1'b0};
            end
        end
    end

    // result register
    logic [31:0] ang;
    always_comb begin
        if (r_small || r_den == '0) begin
            ang = 32'd0;
        end else if (r_neg) begin
            ang = (r_num > NW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-r_num[31:0]);
        end else begin
            ang = (r_num > NW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_num[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit || i_cmd.emit_empty;
        end
        if (i_cmd.emit_empty) begin
            r_out <= '{linear_speed: 20'd0, angular_speed: 32'sd0, plan_empty: 1'b1};
        end else if (i_cmd.emit) begin
            r_out <= '{linear_speed: i_max_lin, angular_speed: ang, plan_empty: 1'b0};
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule

// ===== hdl/pure_pursuit_steering.sv =====
// A load item is taken while idle. A compute item walks the plan from its last point
// (one store read and compare for each point walked), then forms shift-add products
// and runs the serial divider before the result strobe.
// An empty plan answers with a plan_empty result and no walk.
// Throughput: one item at a time, busy high until the result strobe.
// Reset (synchronous, active low) empties the plan and restores default registers;
// stored points are not cleared. Results are strobed for one cycle, no stall.
module pure_pursuit_steering import pps_pkg::*; #(
    parameter int unsigned PLAN_DEPTH = PlanDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output t_out        o_result
);
    logic [23:0] r_look;
    logic [19:0] r_max_lin, r_max_ang;
    t_cmd    cmd;
    t_status status;
    logic    go;

    assign o_cfg_ready = 1'b1;
    assign go = start && !busy && (i_item.cmd == CmdCompute);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look    <= LookaheadReset;
            r_max_lin <= MaxLinReset;
            r_max_ang <= MaxAngReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegLookahead: r_look    <= i_cfg_data[23:0];
                RegMaxLin:    r_max_lin <= i_cfg_data[19:0];
                RegMaxAng:    r_max_ang <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    pps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_status(status),
        .o_cmd(cmd), .o_busy(busy));

    pps_dp #(.PLAN_DEPTH(PLAN_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_in(i_item), .i_cmd(cmd), .i_look(r_look), .i_max_lin(r_max_lin),
        .i_max_ang(r_max_ang), .o_status(status), .o_valid(o_valid),
        .o_out(o_result));

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.plan_empty |-> o_result.linear_speed == 20'd0)
        else $error("empty plan result carries speed");
    a_no_valid_idle_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without compute");
endmodule
